/* design/rea_pkg.sv */
// Package for the RMS error accumulator.
// Holds widths, register indexes, mode codes and the types shared by the block's modules.
// Depends on nothing.
`default_nettype none

package rea_pkg;

    localparam int DATA_W      = 32;
    localparam int SUM_W       = 64;
    localparam int CNT_W       = 13;
    localparam int DIV_W       = 2 * CNT_W;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_W        = 2 * DATA_W;
    localparam int USER_W      = 2;
    localparam int STEP_W      = $clog2(SUM_W);
    localparam int ROOT_STEPS  = SUM_W / 2;
    localparam int SREM_W      = DATA_W + 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int DEF_MAX_ROWS = 4096;
    localparam int DEF_MAX_COLS = 4096;

    localparam logic [MODE_W-1:0] MODE_VECTOR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROW     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COLUMN  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] order_mode;
        logic [CNT_W-1:0]  row_count;
        logic [CNT_W-1:0]  col_count;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] mag;
        logic              last;
        logic              err;
        logic [DIV_W-1:0]  divisor;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ROOT,
        S_OUT
    } t_back_state;

endpackage

`default_nettype wire

/* design/rms_error_accumulator.sv */
// Top level of the RMS error accumulator: configuration registers, front, queue and back.
// Depends on rea_pkg, rea_front, rea_queue and rea_back.
//
//   Port group    Dir   Contents
//   i_s_*         in    tdata: measured_value [31:0], estimate_value [63:32]
//   o_m_*         out   tdata: rms_value [31:0]; tuser: mode_error [0], sum_saturated [1]
//   i_cfg_*       in    write enable, register index, 13-bit write data
//
// The front takes one item per cycle while the four-entry queue has room.
// While idle, the back squares and accumulates one item per cycle.
// The item that completes a matrix sends the back through its divide, root and output
// states; the queue absorbs up to four items meanwhile.
// Sync reset clears sum and count, sets a 1x1 row-order shape; no clearing pass.
// A stalled result stays in the output register while the front keeps accepting items.
`default_nettype none

module rms_error_accumulator #(
    parameter int MAX_ROWS = rea_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = rea_pkg::DEF_MAX_COLS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire [rea_pkg::IN_W-1:0]        i_s_tdata,   // measured_value, estimate_value
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic [rea_pkg::DATA_W-1:0]     o_m_tdata,   // rms_value
    output logic [rea_pkg::USER_W-1:0]     o_m_tuser,   // mode_error, sum_saturated
    input  wire                            i_cfg_we,
    input  wire [rea_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [rea_pkg::CNT_W-1:0]       i_cfg_wdata
);

    rea_pkg::t_cfg     r_cfg;
    rea_pkg::t_entry   w_push_entry;
    rea_pkg::t_entry   w_pop_entry;
    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.order_mode <= rea_pkg::MODE_ROW;
            r_cfg.row_count  <= rea_pkg::CNT_W'(1);
            r_cfg.col_count  <= rea_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rea_pkg::CFG_ORDER_MODE: r_cfg.order_mode <= i_cfg_wdata[rea_pkg::MODE_W-1:0];
                rea_pkg::CFG_ROW_COUNT:  r_cfg.row_count  <= i_cfg_wdata;
                rea_pkg::CFG_COL_COUNT:  r_cfg.col_count  <= i_cfg_wdata;
                default:                 r_cfg            <= r_cfg;
            endcase
        end
    end

    rea_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    rea_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_pop_entry)
    );

    rea_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_entry    (w_pop_entry),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

/* design/rea_front.sv */
// Front part of the RMS error accumulator: accepts items, forms the saturated difference,
// counts items of the matrix and marks the last one. Depends on rea_pkg.
`default_nettype none

module rea_front #(
    parameter int MAX_ROWS = rea_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = rea_pkg::DEF_MAX_COLS
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  rea_pkg::t_cfg              i_cfg,
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    input  wire [rea_pkg::IN_W-1:0]    i_s_tdata,
    input  wire                        i_full,
    output logic                       o_push,
    output rea_pkg::t_entry            o_entry
);

    logic [rea_pkg::DIV_W-1:0]    r_count;
    logic [rea_pkg::DIV_W-1:0]    n_count;
    logic [rea_pkg::DATA_W:0]     w_diff;
    logic [rea_pkg::DATA_W-1:0]   w_sat;
    logic [rea_pkg::DATA_W-1:0]   w_mag;
    logic [rea_pkg::CNT_W-1:0]    w_rows;
    logic [rea_pkg::CNT_W-1:0]    w_cols;
    logic [rea_pkg::DIV_W-1:0]    w_divisor;
    logic [rea_pkg::DIV_W-1:0]    w_expected;
    logic [rea_pkg::DIV_W-1:0]    w_next;
    logic                         w_err;
    logic                         w_last;

    function automatic logic [rea_pkg::CNT_W-1:0] clamp_count(
        input logic [rea_pkg::CNT_W-1:0] value,
        input int                        max_value
    );
        logic [rea_pkg::CNT_W-1:0] result;
        if (value == '0) begin
            result = rea_pkg::CNT_W'(1);
        end else if (32'(value) > 32'(max_value)) begin
            result = rea_pkg::CNT_W'(max_value);
        end else begin
            result = value;
        end
        return result;
    endfunction

    always_comb begin
        w_diff = {i_s_tdata[rea_pkg::DATA_W-1], i_s_tdata[rea_pkg::DATA_W-1:0]}
               - {i_s_tdata[rea_pkg::IN_W-1], i_s_tdata[rea_pkg::IN_W-1:rea_pkg::DATA_W]};
        if (w_diff[rea_pkg::DATA_W] != w_diff[rea_pkg::DATA_W-1]) begin
            w_sat = w_diff[rea_pkg::DATA_W] ? {1'b1, {(rea_pkg::DATA_W-1){1'b0}}}
                                            : {1'b0, {(rea_pkg::DATA_W-1){1'b1}}};
        end else begin
            w_sat = w_diff[rea_pkg::DATA_W-1:0];
        end
        w_mag = w_sat[rea_pkg::DATA_W-1] ? (~w_sat + rea_pkg::DATA_W'(1)) : w_sat;

        w_rows     = clamp_count(i_cfg.row_count, MAX_ROWS);
        w_cols     = clamp_count(i_cfg.col_count, MAX_COLS);
        w_divisor  = rea_pkg::DIV_W'(w_rows) * rea_pkg::DIV_W'(w_cols);
        w_expected = (i_cfg.order_mode == rea_pkg::MODE_VECTOR) ? rea_pkg::DIV_W'(w_rows)
                                                                : w_divisor;
        w_err      = (i_cfg.order_mode == rea_pkg::MODE_INVALID);
        w_next     = r_count + rea_pkg::DIV_W'(1);
        w_last     = (w_next >= w_expected);
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    always_comb begin
        o_entry.mag     = w_mag;
        o_entry.last    = w_last;
        o_entry.err     = w_err;
        o_entry.divisor = w_divisor;
    end

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            n_count = (w_err || w_last) ? '0 : w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* design/rea_queue.sv */
// Short queue between the front and back parts of the RMS error accumulator.
// Depends on rea_pkg for the entry type and depth.
`default_nettype none

module rea_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  rea_pkg::t_entry     i_entry,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output rea_pkg::t_entry     o_entry
);

    rea_pkg::t_entry              r_mem [rea_pkg::QUEUE_DEPTH];
    logic [rea_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [rea_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [rea_pkg::QPTR_W:0]     r_fill;
    logic                         w_do_push;
    logic                         w_do_pop;

    assign o_full    = (r_fill == (rea_pkg::QPTR_W + 1)'(rea_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_fill != '0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + rea_pkg::QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + rea_pkg::QPTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_fill <= r_fill + (rea_pkg::QPTR_W + 1)'(1);
                2'b01:   r_fill <= r_fill - (rea_pkg::QPTR_W + 1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/rea_back.sv */
// Back part of the RMS error accumulator: squares, accumulates with saturation, then
// divides by rows times cols and takes the integer square root. Depends on rea_pkg.
`default_nettype none

module rea_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  rea_pkg::t_entry              i_entry,
    output logic                         o_pop,
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    output logic [rea_pkg::DATA_W-1:0]   o_m_tdata,
    output logic [rea_pkg::USER_W-1:0]   o_m_tuser
);

    rea_pkg::t_back_state          r_state;
    rea_pkg::t_back_state          n_state;

    logic                          r_p_valid;
    logic [rea_pkg::SUM_W-1:0]     r_p_sq;
    logic                          r_p_last;
    logic                          r_p_err;
    logic [rea_pkg::DIV_W-1:0]     r_p_div;

    logic [rea_pkg::SUM_W-1:0]     r_sum;
    logic                          r_sat;
    logic [rea_pkg::SUM_W:0]       w_add;
    logic [rea_pkg::SUM_W-1:0]     w_sum;
    logic                          w_sat;

    logic [rea_pkg::STEP_W-1:0]    r_step;
    logic [rea_pkg::SUM_W-1:0]     r_x;
    logic [rea_pkg::DIV_W-1:0]     r_dv;
    logic [rea_pkg::DIV_W-1:0]     r_rem;
    logic [rea_pkg::DIV_W:0]       w_rem_sh;
    logic                          w_div_ge;
    logic [rea_pkg::DIV_W:0]       w_rem_sub;
    logic [rea_pkg::SREM_W-1:0]    r_srem;
    logic [rea_pkg::DATA_W-1:0]    r_root;
    logic [rea_pkg::SREM_W-1:0]    w_srem_sh;
    logic [rea_pkg::SREM_W-1:0]    w_trial;
    logic                          w_root_ge;
    logic                          r_res_err;
    logic                          r_res_sat;

    logic                          w_out_load;
    logic                          r_out_valid;
    logic [rea_pkg::DATA_W-1:0]    r_out_data;
    logic [rea_pkg::USER_W-1:0]    r_out_user;

    always_comb begin
        w_add = {1'b0, r_sum} + {1'b0, r_p_sq};
        if (w_add[rea_pkg::SUM_W]) begin
            w_sum = '1;
            w_sat = 1'b1;
        end else begin
            w_sum = w_add[rea_pkg::SUM_W-1:0];
            w_sat = r_sat;
        end

        w_rem_sh  = {r_rem, r_x[rea_pkg::SUM_W-1]};
        w_div_ge  = (w_rem_sh >= {1'b0, r_dv});
        w_rem_sub = w_rem_sh - {1'b0, r_dv};

        w_srem_sh = {r_srem[rea_pkg::DATA_W:0], r_x[rea_pkg::SUM_W-1:rea_pkg::SUM_W-2]};
        w_trial   = {1'b0, r_root, 2'b01};
        w_root_ge = (w_srem_sh >= w_trial);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rea_pkg::S_IDLE: begin
                if (r_p_valid && r_p_err) begin
                    n_state = rea_pkg::S_OUT;
                end else if (r_p_valid && r_p_last) begin
                    n_state = rea_pkg::S_DIV;
                end
            end
            rea_pkg::S_DIV: begin
                if (r_step == rea_pkg::STEP_W'(rea_pkg::SUM_W - 1)) begin
                    n_state = rea_pkg::S_ROOT;
                end
            end
            rea_pkg::S_ROOT: begin
                if (r_step == rea_pkg::STEP_W'(rea_pkg::ROOT_STEPS - 1)) begin
                    n_state = rea_pkg::S_OUT;
                end
            end
            rea_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = rea_pkg::S_IDLE;
                end
            end
            default: n_state = rea_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = i_q_valid && (r_state == rea_pkg::S_IDLE)
                   && !(r_p_valid && (r_p_last || r_p_err));
        w_out_load = (r_state == rea_pkg::S_OUT) && (!r_out_valid || i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_sq   <= rea_pkg::SUM_W'(i_entry.mag) * rea_pkg::SUM_W'(i_entry.mag);
            r_p_last <= i_entry.last;
            r_p_err  <= i_entry.err;
            r_p_div  <= i_entry.divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rea_pkg::S_IDLE;
            r_p_valid   <= 1'b0;
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= o_pop;
            if (r_p_valid) begin
                if (r_p_err || r_p_last) begin
                    r_sum <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_sum <= w_sum;
                    r_sat <= w_sat;
                end
            end
            if (r_state != n_state) begin
                r_step <= '0;
            end else if (r_state == rea_pkg::S_DIV || r_state == rea_pkg::S_ROOT) begin
                r_step <= r_step + rea_pkg::STEP_W'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rea_pkg::S_IDLE: begin
                r_rem  <= '0;
                r_srem <= '0;
                r_root <= '0;
                r_x    <= w_sum;
                r_dv   <= r_p_div;
                if (r_p_valid && r_p_err) begin
                    r_res_err <= 1'b1;
                    r_res_sat <= 1'b0;
                end else begin
                    r_res_err <= 1'b0;
                    r_res_sat <= w_sat;
                end
            end
            rea_pkg::S_DIV: begin
                r_rem <= w_div_ge ? w_rem_sub[rea_pkg::DIV_W-1:0]
                                  : w_rem_sh[rea_pkg::DIV_W-1:0];
                r_x   <= {r_x[rea_pkg::SUM_W-2:0], w_div_ge};
            end
            rea_pkg::S_ROOT: begin
                r_srem <= w_root_ge ? (w_srem_sh - w_trial) : w_srem_sh;
                r_root <= {r_root[rea_pkg::DATA_W-2:0], w_root_ge};
                r_x    <= {r_x[rea_pkg::SUM_W-3:0], 2'b00};
            end
            rea_pkg::S_OUT: begin
                r_rem <= r_rem;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= r_res_err ? '0 : r_root;
            r_out_user <= {r_res_sat && !r_res_err, r_res_err};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

/* design/rea_checker.sv */
// Port checker for the RMS error accumulator, with its bind to the top level.
// Depends on rea_pkg and rms_error_accumulator.
`default_nettype none

module rea_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tready,
    input  wire                            i_m_tvalid,
    input  wire                            i_m_tready,
    input  wire [rea_pkg::DATA_W-1:0]      i_m_tdata,
    input  wire [rea_pkg::USER_W-1:0]      i_m_tuser
);

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result offered straight after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_s_tready)
        else $error("input not ready straight after reset");

    a_error_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser[0]) |-> (i_m_tdata == '0 && !i_m_tuser[1]))
        else $error("mode error result carries a value or a saturation flag");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result changed");

endmodule

bind rms_error_accumulator rea_checker u_rea_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

`default_nettype wire

/* tb/tb_rms_error_accumulator.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rms_error_accumulator: streams measured/estimate pairs under
// several matrix shapes and order modes, and checks every RMS result against a predictor.
// Depends on rea_pkg and the rms_error_accumulator RTL.

module tb_rms_error_accumulator;
    import rea_pkg::*;

    localparam int DRAIN_CYCLES = 256;
    localparam int ROW_LIMIT    = DEF_MAX_ROWS;
    localparam int COL_LIMIT    = DEF_MAX_COLS;
    localparam int LONG_ROWS    = 200;
    localparam int RANDOM_PAIRS = 680;
    localparam int CALM_PAIRS   = 150;

    typedef struct {
        logic [DATA_W-1:0] rms;
        logic              mode_err;
        logic              sat;
    } rms_result_t;

    class rms_predictor;
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  rows_reg;
        logic [CNT_W-1:0]  cols_reg;
        logic [SUM_W-1:0]  acc;
        int unsigned       taken;
        logic              acc_sat;
        rms_result_t       due_q[$];
        int unsigned       mismatches;

        function new();
            mode       = MODE_ROW;
            rows_reg   = 1;
            cols_reg   = 1;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            acc     = '0;
            taken   = 0;
            acc_sat = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
            case (idx)
                CFG_ORDER_MODE: mode = val[MODE_W-1:0];
                CFG_ROW_COUNT:  rows_reg = val;
                CFG_COL_COUNT:  cols_reg = val;
                default: ;
            endcase
        endfunction

        function logic [63:0] clamp_dim(logic [CNT_W-1:0] v, int unsigned lim);
            if (v == 0) return 64'd1;
            if (v > lim) return 64'(lim);
            return 64'(v);
        endfunction

        function logic [63:0] floor_root(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] c;
            r = '0;
            for (int i = 31; i >= 0; i--) begin
                c = r | (64'd1 << i);
                if (c * c <= x) r = c;
            end
            return r;
        endfunction

        function void take_pair(logic [DATA_W-1:0] meas, logic [DATA_W-1:0] est);
            logic signed [63:0] diff;
            logic [63:0]        mag;
            logic [63:0]        sq;
            logic [63:0]        rows;
            logic [63:0]        cols;
            logic [63:0]        divisor;
            logic [63:0]        need;
            rms_result_t        r;
            if (mode == MODE_INVALID) begin
                restart();
                r.rms      = '0;
                r.mode_err = 1'b1;
                r.sat      = 1'b0;
                due_q.push_back(r);
                return;
            end
            diff = $signed({{32{meas[31]}}, meas}) - $signed({{32{est[31]}}, est});
            if (diff > 64'sd2147483647) diff = 64'sd2147483647;
            else if (diff < -64'sd2147483648) diff = -64'sd2147483648;
            if (diff < 0) mag = -diff;
            else mag = diff;
            sq = mag * mag;
            if (acc > ~sq) begin
                acc     = '1;
                acc_sat = 1'b1;
            end else begin
                acc = acc + sq;
            end
            taken++;
            rows    = clamp_dim(rows_reg, ROW_LIMIT);
            cols    = clamp_dim(cols_reg, COL_LIMIT);
            divisor = rows * cols;
            need    = (mode == MODE_VECTOR) ? rows : divisor;
            if (64'(taken) < need) return;
            r.rms      = DATA_W'(floor_root(acc / divisor));
            r.mode_err = 1'b0;
            r.sat      = acc_sat;
            due_q.push_back(r);
            restart();
        endfunction

        function void match_result(logic [DATA_W-1:0] rms, logic [USER_W-1:0] user);
            rms_result_t want;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none due: rms %h mode_error %b sum_saturated %b",
                             $time, rms, user[0], user[1]);
                return;
            end
            want = due_q.pop_front();
            if (rms !== want.rms || user[0] !== want.mode_err || user[1] !== want.sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: rms %h/%h mode_error %b/%b sum_saturated %b/%b (exp/act)",
                             $time, want.rms, rms, want.mode_err, user[0], want.sat, user[1]);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tready  = 1'b1;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ORDER_MODE;
    logic [CNT_W-1:0]      cfg_wdata = '0;
    bit                    idle_on   = 1'b1;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [DATA_W-1:0]      m_tdata;
    wire [USER_W-1:0]      m_tuser;

    rms_predictor rms_model = new();

    rms_error_accumulator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_pair(input logic [DATA_W-1:0] meas, input logic [DATA_W-1:0] est);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {est, meas};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        rms_model.take_pair(meas, est);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (rms_model.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [MODE_W-1:0] mode, input logic [CNT_W-1:0] rows,
                             input logic [CNT_W-1:0] cols);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ORDER_MODE;
        cfg_wdata <= CNT_W'(mode);
        rms_model.write_reg(CFG_ORDER_MODE, CNT_W'(mode));
        @(posedge i_clk);
        cfg_index <= CFG_ROW_COUNT;
        cfg_wdata <= rows;
        rms_model.write_reg(CFG_ROW_COUNT, rows);
        @(posedge i_clk);
        cfg_index <= CFG_COL_COUNT;
        cfg_wdata <= cols;
        rms_model.write_reg(CFG_COL_COUNT, cols);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] corner_value();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic make_pair(input int unsigned wild_pct, output logic [DATA_W-1:0] meas,
                             output logic [DATA_W-1:0] est);
        int unsigned        pick;
        logic signed [31:0] delta;
        pick = $urandom_range(0, 99);
        meas = $urandom;
        if (pick < wild_pct) begin
            est = $urandom;
        end else if (pick < wild_pct + wild_pct / 3) begin
            meas = corner_value();
            est  = corner_value();
        end else begin
            delta = $urandom;
            delta = delta >>> $urandom_range(4, 31);
            est   = meas + delta;
        end
    endtask

    initial begin
        int unsigned       stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rst_n && m_tvalid && m_tready) rms_model.match_result(m_tdata, m_tuser);
            if (stall_left != 0) begin
                stall_left--;
                if (stall_left == 0) m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10);
                m_tready   <= 1'b0;
            end
        end
    end

    initial begin
        logic [DATA_W-1:0] meas;
        logic [DATA_W-1:0] est;
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  rows;
        logic [CNT_W-1:0]  cols;
        int unsigned       sent;
        int unsigned       sel;
        int unsigned       burst;

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset shape is a one-by-one matrix in row order, so every item gives a result.
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        settle();

        // Four full-scale squares overflow the sum.
        load_regs(MODE_ROW, 2, 2);
        repeat (4) send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        settle();

        load_regs(MODE_COLUMN, 0, 3);
        send_pair(32'h0000_0001, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFB, 32'h0000_0003);
        settle();

        load_regs(MODE_VECTOR, 3, 13'h1FFF);
        send_pair(32'h0001_0000, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'h0001_0000);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        settle();

        load_regs(MODE_INVALID, 13'h1FFF, 0);
        send_pair(32'h1234_5678, 32'h8765_4321);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000);
        settle();

        // Shrinking the matrix part way through completes it on the next item.
        load_regs(MODE_ROW, 2, 2);
        send_pair(32'h0003_0000, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'h0004_0000);
        settle();
        load_regs(MODE_ROW, 1, 1);
        send_pair(32'h0000_0000, 32'h0000_0000);
        settle();

        // An invalid-mode item discards a partial matrix.
        load_regs(MODE_ROW, 2, 2);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        settle();
        load_regs(MODE_INVALID, 2, 2);
        send_pair(32'h0000_0000, 32'h0000_0000);
        settle();
        load_regs(MODE_ROW, 2, 2);
        send_pair(32'h0000_0100, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'h0000_0200);
        send_pair(32'h0000_0300, 32'h0000_0000);
        send_pair(32'hFFFF_FF00, 32'h0000_0000);
        settle();

        // A long vector over a clamped column count gives a large divisor.
        load_regs(MODE_VECTOR, CNT_W'(LONG_ROWS), 13'h1FFF);
        repeat (LONG_ROWS) begin
            make_pair(0, meas, est);
            send_pair(meas, est);
        end
        settle();

        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            sel = $urandom_range(0, 9);
            if (sel < 3) begin
                mode = MODE_VECTOR;
                rows = CNT_W'($urandom_range(0, 12));
                cols = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom)
                                                   : CNT_W'($urandom_range(0, 6));
            end else if (sel < 9) begin
                mode = (sel < 6) ? MODE_ROW : MODE_COLUMN;
                rows = CNT_W'($urandom_range(0, 6));
                cols = CNT_W'($urandom_range(0, 6));
            end else begin
                mode = MODE_INVALID;
                rows = CNT_W'($urandom);
                cols = CNT_W'($urandom);
            end
            load_regs(mode, rows, cols);
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_PAIRS; k++) begin
                if (sent == RANDOM_PAIRS - CALM_PAIRS) idle_on = 1'b0;
                make_pair(35, meas, est);
                send_pair(meas, est);
                sent++;
                if ($urandom_range(0, 49) == 0) settle();
            end
            settle();
        end

        if (rms_model.mismatches == 0 && rms_model.pending() == 0) begin
            $display("tb_rms_error_accumulator OK");
        end else begin
            $display("tb_rms_error_accumulator NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_rms_error_accumulator NOT OK");
        $finish;
    end

endmodule
